// File: src/mds_pkg.sv
// ----------------------------------------------------------------------------
// mds_pkg: shared types and constants for the multibyte delimiter splitter
// Item layouts of both channels, configuration register codes and reset values.
// ----------------------------------------------------------------------------
package mds_pkg;

  localparam int BYTE_W     = 8;
  localparam int SEP_LEN_W  = 4;
  localparam int CFG_DATA_W = 64;

  localparam logic [SEP_LEN_W-1:0]  SEP_LEN_RESET   = 4'd1;
  localparam logic [CFG_DATA_W-1:0] SEP_BYTES_RESET = 64'd44;

  typedef enum logic [0:0] {
    REG_SEP_LEN   = 1'b0,
    REG_SEP_BYTES = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              has_data;
    logic              end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              segment_end;
    logic              source_done;
    logic              run_last;
  } out_item_t;

endpackage

// File: src/mds_in_if.sv
// ----------------------------------------------------------------------------
// mds_in_if: source byte channel
// Valid/ready channel that carries one source item per request.
// ----------------------------------------------------------------------------
interface mds_in_if;
  import mds_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: src/mds_out_if.sv
// ----------------------------------------------------------------------------
// mds_out_if: segment result channel
// Valid/ready channel that carries one result item per request.
// ----------------------------------------------------------------------------
interface mds_out_if;
  import mds_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: src/mds_cfg.sv
// ----------------------------------------------------------------------------
// mds_cfg: separator configuration registers
// Holds separator length and bytes and derives the length in use.
// ----------------------------------------------------------------------------
module mds_cfg #(
  parameter int MAX_SEP = 8,
  parameter int LW      = $clog2(MAX_SEP + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  mds_pkg::cfg_reg_t              cfg_index,
  input  logic [mds_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [LW-1:0]                  eff_len,
  output logic [mds_pkg::CFG_DATA_W-1:0] sep_bytes
);
  import mds_pkg::*;

  logic [SEP_LEN_W-1:0] sep_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      sep_len   <= SEP_LEN_RESET;
      sep_bytes <= SEP_BYTES_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SEP_LEN:   sep_len   <= cfg_data[SEP_LEN_W-1:0];
        REG_SEP_BYTES: sep_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // Zero length acts as one byte; anything past the window depth saturates.
  always_comb begin
    if (sep_len == '0) begin
      eff_len = LW'(1);
    end else if (sep_len > SEP_LEN_W'(MAX_SEP)) begin
      eff_len = LW'(MAX_SEP);
    end else begin
      eff_len = sep_len[LW-1:0];
    end
  end

endmodule

// File: src/mds_core.sv
// ----------------------------------------------------------------------------
// mds_core: item register, match window and step sequencer
// One step of the held item per stall-free cycle, with at most one result out.
// ----------------------------------------------------------------------------
module mds_core #(
  parameter int MAX_SEP = 8,
  parameter int LW      = $clog2(MAX_SEP + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  mds_in_if.sink                         source,
  input  logic [LW-1:0]                  eff_len,
  input  logic [mds_pkg::CFG_DATA_W-1:0] sep_bytes,
  input  logic                           out_free,
  output logic                           emit,
  output mds_pkg::out_item_t             emit_item
);
  import mds_pkg::*;

  logic              pend;
  in_item_t          item;
  logic              data_done;
  logic [BYTE_W-1:0] win [MAX_SEP];
  logic [LW-1:0]     fill;

  logic [BYTE_W-1:0] win_next [MAX_SEP];
  logic [LW-1:0]     fill_next;
  logic [BYTE_W-1:0] ins_win [MAX_SEP];
  logic [BYTE_W-1:0] pop_src [MAX_SEP];
  logic [LW-1:0]     ins_fill;
  logic              has_step;
  logic              end_step;
  logic              drain;
  logic              hit;
  logic              match;
  logic              needs_emit;
  logic              go;
  logic              item_done;
  logic              set_data_done;
  logic              do_pop;
  logic              do_clear;
  logic              do_insert;
  logic              accept;

  assign has_step = pend && item.has_data && !data_done;
  assign end_step = pend && item.end_of_source && (data_done || !item.has_data);
  // A lowered length leaves a window at or above it; those bytes go out first.
  assign drain    = has_step && (fill >= eff_len);
  assign ins_fill = fill + LW'(1);
  assign hit      = ins_fill == eff_len;

  always_comb begin
    for (int k = 0; k < MAX_SEP; k++) begin
      ins_win[k] = (LW'(k) == fill) ? item.data_byte : win[k];
    end
  end

  always_comb begin
    match = 1'b1;
    for (int k = 0; k < MAX_SEP; k++) begin
      if ((LW'(k) < eff_len) && (ins_win[k] != sep_bytes[BYTE_W*k +: BYTE_W])) begin
        match = 1'b0;
      end
    end
  end

  assign needs_emit = drain || (has_step && hit) || end_step;
  assign go         = !needs_emit || out_free;
  assign emit       = needs_emit && out_free;

  always_comb begin
    emit_item     = '0;
    do_pop        = 1'b0;
    do_clear      = 1'b0;
    do_insert     = 1'b0;
    item_done     = 1'b0;
    set_data_done = 1'b0;
    if (has_step && drain) begin
      emit_item.out_byte   = win[0];
      emit_item.byte_valid = 1'b1;
      do_pop               = 1'b1;
    end else if (has_step) begin
      do_insert = 1'b1;
      if (hit && match) begin
        emit_item.segment_end = 1'b1;
        emit_item.run_last    = !item.end_of_source;
        do_clear              = 1'b1;
      end else if (hit) begin
        emit_item.out_byte   = ins_win[0];
        emit_item.byte_valid = 1'b1;
        emit_item.run_last   = !item.end_of_source;
        do_pop               = 1'b1;
      end
      item_done     = !item.end_of_source;
      set_data_done = item.end_of_source;
    end else if (end_step && (fill != '0)) begin
      emit_item.out_byte   = win[0];
      emit_item.byte_valid = 1'b1;
      do_pop               = 1'b1;
    end else if (end_step) begin
      emit_item.segment_end = 1'b1;
      emit_item.source_done = 1'b1;
      emit_item.run_last    = 1'b1;
      do_clear              = 1'b1;
      item_done             = 1'b1;
    end else if (pend) begin
      // An item with neither a byte nor an end leaves no trace.
      item_done = 1'b1;
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_SEP; k++) begin
      pop_src[k] = do_insert ? ins_win[k] : win[k];
    end
    fill_next = do_insert ? ins_fill : fill;
    for (int k = 0; k < MAX_SEP; k++) begin
      win_next[k] = pop_src[k];
    end
    if (do_clear) begin
      for (int k = 0; k < MAX_SEP; k++) begin
        win_next[k] = '0;
      end
      fill_next = '0;
    end else if (do_pop) begin
      for (int k = 0; k < MAX_SEP - 1; k++) begin
        win_next[k] = pop_src[k + 1];
      end
      win_next[MAX_SEP - 1] = '0;
      fill_next = fill_next - LW'(1);
    end
  end

  assign source.ready = !pend || (go && item_done);
  assign accept       = source.valid && source.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      data_done <= 1'b0;
      fill      <= '0;
      for (int k = 0; k < MAX_SEP; k++) begin
        win[k] <= '0;
      end
    end else begin
      if (go) begin
        win  <= win_next;
        fill <= fill_next;
      end
      if (accept) begin
        pend      <= 1'b1;
        data_done <= 1'b0;
      end else if (go && item_done) begin
        pend <= 1'b0;
      end else if (go && set_data_done) begin
        data_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= source.payload;
    end
  end

endmodule

// File: src/multibyte_delimiter_splitter.sv
// ----------------------------------------------------------------------------
// multibyte_delimiter_splitter: split a byte stream on a multibyte separator
//
//   channel  | dir | carries
//   ---------+-----+------------------------------------------------------
//   source   | in  | data_byte, has_data, end_of_source
//   result   | out | out_byte, byte_valid, segment_end, source_done, run_last
//   cfg_*    | in  | separator_length (index 0), separator_bytes (index 1)
//
// A new request is taken every cycle while the window length stays put and
// no result stalls. Each extra result of an item adds a step: up to
// MAX_SEP - 1 drain pops after a lowered length, and fill + 1 results for an
// end flush. The single result register and the window sequencer set this
// pacing. Reset is synchronous and empties the window; no clearing pass
// follows. A stalled result holds the window until the register drains.
// ----------------------------------------------------------------------------
module multibyte_delimiter_splitter #(
  parameter int MAX_SEP = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  mds_in_if.sink                         source,
  mds_out_if.source                      result,
  input  logic                           cfg_write,
  input  mds_pkg::cfg_reg_t              cfg_index,
  input  logic [mds_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mds_pkg::*;

  localparam int LW = $clog2(MAX_SEP + 1);

  logic [LW-1:0]         eff_len;
  logic [CFG_DATA_W-1:0] sep_bytes;
  logic                  out_free;
  logic                  emit;
  out_item_t             emit_item;
  logic                  res_valid;
  out_item_t             res_item;

  mds_cfg #(.MAX_SEP(MAX_SEP), .LW(LW)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .eff_len   (eff_len),
    .sep_bytes (sep_bytes)
  );

  mds_core #(.MAX_SEP(MAX_SEP), .LW(LW)) u_core (
    .clk       (clk),
    .rst       (rst),
    .source    (source),
    .eff_len   (eff_len),
    .sep_bytes (sep_bytes),
    .out_free  (out_free),
    .emit      (emit),
    .emit_item (emit_item)
  );

  assign out_free = !res_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_item <= emit_item;
    end
  end

  assign result.valid   = res_valid;
  assign result.payload = res_item;

endmodule

// File: src/mds_checker.sv
// ----------------------------------------------------------------------------
// mds_checker: port-level checks on the splitter result channel
// Watches result requests for holding under stall and for consistent flags.
// ----------------------------------------------------------------------------
module mds_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] res_byte,
  input logic       res_byte_valid,
  input logic       res_seg_end,
  input logic       res_done,
  input logic       res_last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_byte) &&
      $stable(res_byte_valid) && $stable(res_seg_end) && $stable(res_done) &&
      $stable(res_last))
    else $error("result request changed while stalled");

  // The final segment end of a source always closes the run of its item.
  a_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_done |-> res_seg_end && res_last && !res_byte_valid)
    else $error("source end without segment end or run end");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_byte_valid != res_seg_end)
    else $error("result is neither a byte nor a segment end");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_byte_valid |-> res_byte == 8'd0)
    else $error("segment end carries a nonzero byte");

endmodule

bind multibyte_delimiter_splitter mds_checker u_mds_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .res_byte       (result.payload.out_byte),
  .res_byte_valid (result.payload.byte_valid),
  .res_seg_end    (result.payload.segment_end),
  .res_done       (result.payload.source_done),
  .res_last       (result.payload.run_last)
);

// File: tb/sv/multibyte_delimiter_splitter_tb.sv
// ----------------------------------------------------------------------------
// multibyte_delimiter_splitter_tb: self-checking bench for the delimiter splitter
// A queue-fed driver sends source requests while a monitor predicts the split
// results of each accepted request and compares every returned result with
// them. Directed sources come first, then random sources over several separator
// settings, with random gaps on the source side and stalls on the result side.
// ----------------------------------------------------------------------------
module multibyte_delimiter_splitter_tb;
  import mds_pkg::*;

  localparam int SEP_DEPTH     = 8;
  localparam int SETTLE_CYCLES = 2 * SEP_DEPTH + 4;
  localparam int PHASE_ITEMS   = 26;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mds_in_if  src_ch ();
  mds_out_if res_ch ();

  multibyte_delimiter_splitter #(
    .MAX_SEP(SEP_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .source   (src_ch),
    .result   (res_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  int send_idle_pct;
  int stall_pct;
  int errors;
  int phase_items;

  in_item_t  byte_req_q [$];
  out_item_t segment_q [$];

  // Predictor state: separator settings and the match window.
  logic [SEP_LEN_W-1:0]  cur_sep_len;
  logic [CFG_DATA_W-1:0] cur_sep_bytes;
  logic [7:0]            win_bytes [SEP_DEPTH];
  int unsigned           win_fill;
  out_item_t             held_result;
  bit                    held_valid;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int unsigned sep_span();
    if (cur_sep_len == 0) return 1;
    if (cur_sep_len > SEP_DEPTH) return SEP_DEPTH;
    return int'(cur_sep_len);
  endfunction

  function automatic logic [7:0] sep_byte(int unsigned k);
    return cur_sep_bytes[8*k +: 8];
  endfunction

  function automatic logic [7:0] shift_out();
    logic [7:0] b;
    b = win_bytes[0];
    for (int k = 1; k < SEP_DEPTH; k++) win_bytes[k-1] = win_bytes[k];
    win_bytes[SEP_DEPTH-1] = 8'h00;
    if (win_fill > 0) win_fill--;
    return b;
  endfunction

  function automatic bit window_is_sep(int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      if (win_bytes[k] != sep_byte(k)) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_window();
    for (int k = 0; k < SEP_DEPTH; k++) win_bytes[k] = 8'h00;
    win_fill = 0;
  endtask

  // The newest result is held back so that run_last can be set on it.
  task automatic emit(logic [7:0] b, logic bv, logic se, logic sd);
    if (held_valid) segment_q.push_back(held_result);
    held_result.out_byte    = b;
    held_result.byte_valid  = bv;
    held_result.segment_end = se;
    held_result.source_done = sd;
    held_result.run_last    = 1'b0;
    held_valid = 1'b1;
  endtask

  task automatic split_item(in_item_t it);
    int unsigned n;
    n = sep_span();
    held_valid = 1'b0;
    if (it.has_data) begin
      // A lowered length drains the oldest bytes before the new one enters.
      while (win_fill >= n && win_fill > 0) emit(shift_out(), 1'b1, 1'b0, 1'b0);
      if (win_fill < SEP_DEPTH) begin
        win_bytes[win_fill] = it.data_byte;
        win_fill++;
      end
      if (win_fill == n) begin
        if (window_is_sep(n)) begin
          clear_window();
          emit(8'h00, 1'b0, 1'b1, 1'b0);
        end else begin
          emit(shift_out(), 1'b1, 1'b0, 1'b0);
        end
      end
    end
    if (it.end_of_source) begin
      while (win_fill > 0) emit(shift_out(), 1'b1, 1'b0, 1'b0);
      clear_window();
      emit(8'h00, 1'b0, 1'b1, 1'b1);
    end
    if (held_valid) begin
      held_result.run_last = 1'b1;
      segment_q.push_back(held_result);
    end
  endtask

  task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
      errors++;
    end
  endtask

  // Source driver: a new request is offered once the previous one is taken.
  always @(posedge clk) begin
    if (rst) begin
      src_ch.valid <= 1'b0;
    end else if (!src_ch.valid || src_ch.ready) begin
      if (byte_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        src_ch.valid   <= 1'b1;
        src_ch.payload <= byte_req_q.pop_front();
      end else begin
        src_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (src_ch.valid && src_ch.ready) split_item(src_ch.payload);
      if (res_ch.valid && res_ch.ready) begin
        if (segment_q.size() == 0) begin
          $display("%0t: no result expected, actual %0h", $time, res_ch.payload);
          errors++;
        end else begin
          want = segment_q.pop_front();
          check_field("out_byte", want.out_byte, res_ch.payload.out_byte);
          check_field("byte_valid", want.byte_valid, res_ch.payload.byte_valid);
          check_field("segment_end", want.segment_end, res_ch.payload.segment_end);
          check_field("source_done", want.source_done, res_ch.payload.source_done);
          check_field("run_last", want.run_last, res_ch.payload.run_last);
        end
      end
    end
  end

  task automatic send_item(logic [7:0] d, logic has, logic eos);
    in_item_t it;
    it.data_byte     = d;
    it.has_data      = has;
    it.end_of_source = eos;
    byte_req_q.push_back(it);
    if (has || eos) phase_items++;
  endtask

  // Registers change only while the block is idle, so the predictor follows at once.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_SEP_LEN) cur_sep_len = val[SEP_LEN_W-1:0];
    else cur_sep_bytes = val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (byte_req_q.size() != 0 || src_ch.valid || segment_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One source built from random bytes, whole separators and cut-off separators.
  task automatic gen_source(bit close);
    int unsigned n;
    int unsigned pick;
    int unsigned cut;
    n = sep_span();
    repeat ($urandom_range(0, 5)) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        repeat ($urandom_range(1, 3)) send_item(8'($urandom_range(255)), 1'b1, 1'b0);
      end else if (pick < 60) begin
        for (int unsigned k = 0; k < n; k++) send_item(sep_byte(k), 1'b1, 1'b0);
      end else if (pick < 80) begin
        cut = (n > 1) ? $urandom_range(1, n - 1) : 1;
        for (int unsigned k = 0; k < cut; k++) send_item(sep_byte(k), 1'b1, 1'b0);
      end else if (pick < 90) begin
        send_item(sep_byte($urandom_range(0, n - 1)), 1'b1, 1'b0);
      end else begin
        send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      end
    end
    if (close) begin
      pick = $urandom_range(0, 2);
      if (pick == 0) begin
        send_item(8'($urandom_range(255)), 1'b0, 1'b1);
      end else if (pick == 1) begin
        send_item(8'($urandom_range(255)), 1'b1, 1'b1);
      end else begin
        for (int unsigned k = 0; k < n; k++) send_item(sep_byte(k), 1'b1, k == n - 1);
      end
    end
  endtask

  initial begin
    int unsigned sep_lens [6];
    logic [7:0]  rb;
    sep_lens = '{8, 3, 1, 15, 0, 2};
    errors = 0;
    phase_items = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    cur_sep_len = SEP_LEN_RESET;
    cur_sep_bytes = SEP_BYTES_RESET;
    held_valid = 1'b0;
    clear_window();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_SEP_LEN;
    cfg_data = '0;
    src_ch.valid = 1'b0;
    src_ch.payload = '0;
    res_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset separator: empty source, a request that does nothing, a split, a trailing match.
    send_item(8'h5A, 1'b0, 1'b1);
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h2C, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h2C, 1'b1, 1'b1);
    wait_idle();

    // Oversized length saturates; the source is left open with SEP_DEPTH - 1 bytes in the window.
    write_reg(REG_SEP_LEN, 64'd15);
    write_reg(REG_SEP_BYTES, {CFG_DATA_W{1'b1}});
    @(negedge clk);
    repeat (SEP_DEPTH) send_item(8'hFF, 1'b1, 1'b0);
    for (int k = 1; k < SEP_DEPTH; k++) send_item(8'(k), 1'b1, 1'b0);
    wait_idle();

    // Zero length acts as one, and the lowered length drains the open window.
    write_reg(REG_SEP_LEN, 64'd0);
    write_reg(REG_SEP_BYTES, '0);
    @(negedge clk);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      rb = 8'($urandom_range(255));
      write_reg(REG_SEP_LEN, 64'(sep_lens[p]));
      if (p == 2) write_reg(REG_SEP_BYTES, '0);
      else if (p == 5) write_reg(REG_SEP_BYTES, {8{rb}});
      else write_reg(REG_SEP_BYTES, {$urandom, $urandom});
      @(negedge clk);
      send_idle_pct = (p % 4 == 1) ? 66 : (p % 4 == 3) ? 36 : 0;
      stall_pct = (p % 4 == 2) ? 66 : (p % 4 == 3) ? 36 : 0;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) gen_source(1'b1);
      if ($urandom_range(1) == 1) gen_source(1'b0);
      wait_idle();
    end

    if (errors == 0) begin
      $display("multibyte_delimiter_splitter: match");
    end else begin
      $display("multibyte_delimiter_splitter: mismatch");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("multibyte_delimiter_splitter: mismatch");
    $finish;
  end

endmodule
